/* design/csfb_pkg.sv */
// ----------------------------------------------------------------------------
// csfb_pkg - shared types and constants for the scope frame builder
// Frame geometry, CRC constants, the queue entry and the back-end phases.
// ----------------------------------------------------------------------------
`default_nettype none

package csfb_pkg;

  // Frame geometry
  localparam int PAYLOAD_BYTES = 8;
  localparam int POS_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int SPAN_W        = 4;
  localparam int CMP_W         = (POS_W > SPAN_W) ? POS_W : SPAN_W;

  // Reflected CRC-16, Modbus flavour
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 4'd8;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/csfb_front.sv */
// ----------------------------------------------------------------------------
// csfb_front - byte intake and CRC accumulation
// Takes payload bytes, folds the covered ones into the CRC, tags the last
// byte of the frame and pushes an entry into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csfb_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         data_byte,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [csfb_pkg::SPAN_W-1:0] span,
  input  wire csfb_pkg::q_stat_t  q_stat,
  output logic                    push,
  output csfb_pkg::q_entry_t      push_entry
);
  import csfb_pkg::*;

  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             covered;
  logic             last;

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Classify the byte
  assign covered = CMP_W'(pos) < CMP_W'(span);
  assign last    = pos == POS_W'(PAYLOAD_BYTES - 1);

  always_comb begin
    crc_next = covered ? crc_fold(crc, data_byte) : crc;
    pos_next = last ? '0 : pos + POS_W'(1);
  end

  assign push_entry.data = data_byte;
  assign push_entry.last = last;
  assign push_entry.crc  = crc_next;

  // Advance CRC and position; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
      pos <= '0;
    end else if (push) begin
      crc <= last ? CRC_INIT : crc_next;
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

/* design/csfb_queue.sv */
// ----------------------------------------------------------------------------
// csfb_queue - short queue between front and back
// Small first-in first-out store of classified bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module csfb_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire csfb_pkg::q_entry_t push_entry,
  input  wire logic               pop,
  output csfb_pkg::q_entry_t      head,
  output csfb_pkg::q_stat_t       q_stat
);
  import csfb_pkg::*;

  q_entry_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign q_stat.full  = count == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = count == '0;
  assign head         = slots[rd_ptr];

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_stat.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

endmodule

`default_nettype wire

/* design/csfb_back.sv */
// ----------------------------------------------------------------------------
// csfb_back - frame byte sequencer
// Emits each queued byte; after the last payload byte also emits the CRC
// low and high bytes, marking the high byte as end of frame.
// ----------------------------------------------------------------------------
`default_nettype none

module csfb_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csfb_pkg::q_entry_t head,
  input  wire csfb_pkg::q_stat_t  q_stat,
  output logic                    pop,
  output logic [7:0]              out_byte,
  output logic                    frame_end,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import csfb_pkg::*;

  phase_t     state;
  phase_t     state_next;
  logic       load;
  logic       take;
  logic [7:0] byte_next;
  logic       end_next;

  // Output register frees when empty or drained
  assign load = !out_valid || out_ready;
  assign take = load && !q_stat.empty;

  // Next phase, beat contents and queue pop
  always_comb begin
    state_next = state;
    byte_next  = head.data;
    end_next   = 1'b0;
    pop        = 1'b0;
    case (state)
      PH_DATA: begin
        byte_next = head.data;
        if (take) begin
          if (head.last) state_next = PH_CRC_LO;
          else           pop = 1'b1;
        end
      end
      PH_CRC_LO: begin
        byte_next = head.crc[7:0];
        if (take) state_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_next = head.crc[15:8];
        end_next  = 1'b1;
        if (take) begin
          state_next = PH_DATA;
          pop        = 1'b1;
        end
      end
      default: begin
        state_next = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_DATA;
    end else begin
      state <= state_next;
    end
  end

  // Hold or reload the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte  <= byte_next;
      frame_end <= end_next;
    end
  end

  a_pop_on_entry_end: assert property (@(posedge clk) disable iff (rst)
    pop |-> ((state == PH_DATA && !head.last) || state == PH_CRC_HI))
    else $error("entry popped before all its beats were sent");

  a_crc_entry_held: assert property (@(posedge clk) disable iff (rst)
    (state != PH_DATA) |-> !q_stat.empty)
    else $error("CRC phase without a queued entry");

  a_end_after_hi: assert property (@(posedge clk) disable iff (rst)
    (take && state == PH_CRC_HI) |=> (out_valid && frame_end && state == PH_DATA))
    else $error("frame end beat not presented after CRC high");

endmodule

`default_nettype wire

/* design/crc16_scope_frame_builder_unit.sv */
// ----------------------------------------------------------------------------
// crc16_scope_frame_builder_unit - scope frame builder with CRC-16 trailer
// Passes payload bytes through and appends a Modbus CRC-16 after each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (data_byte, in_valid, in_ready) takes one payload byte per
//   beat. Output channel (out_byte, frame_end, out_valid, out_ready) gives
//   every payload byte, and after the eighth byte of a frame the CRC low and
//   the CRC high byte, the latter with frame_end set.
//   Config channel (crc_span, cfg_valid, cfg_ready) sets how many leading
//   payload bytes the CRC covers; cfg_ready is always high.
//   Path: an accepted byte is written into the queue, then loaded into the
//   output register. The input takes one byte per cycle while the four-entry
//   queue has room; the output sends one beat per cycle while the receiver is
//   ready and the queue holds an entry, so a frame of 8 bytes leaves as 10
//   output beats: the sustained rate is 8 input bytes per 10 output beats.
//   Reset: CRC returns to 0xFFFF, byte position to zero, span to 8, queue
//   and output register empty.
//   Output stall: the output beat holds; the queue fills and then in_ready
//   drops until the receiver takes beats again.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_scope_frame_builder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output logic [7:0]                       out_byte,
  output logic                             frame_end,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire logic [csfb_pkg::SPAN_W-1:0] crc_span,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready
);
  import csfb_pkg::*;

  logic [SPAN_W-1:0] span;
  logic              push;
  logic              pop;
  q_entry_t          push_entry;
  q_entry_t          head;
  q_stat_t           q_stat;

  // Span register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      span <= crc_span;
    end
  end

  csfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .span       (span),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  csfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  csfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_byte   (out_byte),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

`default_nettype wire

/* bench/crc16_scope_frame_builder_unit_tb.sv */
// ----------------------------------------------------------------------------
// crc16_scope_frame_builder_unit_tb - self-checking bench for the frame builder
// Streams payload bytes through the block under several CRC span settings
// and compares every output beat, including the CRC trailer and the frame
// end flag, against a bit-serial CRC-16 predictor kept in the bench.
// ----------------------------------------------------------------------------
module crc16_scope_frame_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csfb_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_BYTES  = 406;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_beat_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic [7:0]        data_byte = 8'h00;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        out_byte;
  logic              frame_end;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SPAN_W-1:0] crc_span  = SPAN_RESET;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;

  // Predictor state
  logic [15:0]       frame_crc;
  int                frame_pos;
  logic [SPAN_W-1:0] span_setting;
  frame_beat_t       pending_beats[$];
  frame_beat_t       head_beat;

  // Traffic shaping
  bit                quiet     = 1'b0;
  int                stall_pct = 25;
  int                stall_left;

  // Run statistics
  int                mismatches;
  int                bytes_sent;
  int                frames_done;
  int                span_writes;
  logic [15:0]       spans_seen;
  int                cycle_count;

  crc16_scope_frame_builder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_span  (crc_span),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Bit-serial Modbus CRC: shift in one data bit per step, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Favour the extremes of the span register
  function automatic logic [SPAN_W-1:0] pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return SPAN_W'(PAYLOAD_BYTES);
    if (r == 2) return '1;
    if (r == 3) return SPAN_W'($urandom_range(PAYLOAD_BYTES + 1, 14));
    return SPAN_W'($urandom_range(1, PAYLOAD_BYTES - 1));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Queue the beats one accepted payload byte gives rise to
  task automatic build_frame_beats(input logic [7:0] b);
    int eff_span;
    eff_span = (int'(span_setting) > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(span_setting);
    pending_beats.push_back('{value: b, last: 1'b0});
    if (frame_pos < eff_span) frame_crc = crc16_update(frame_crc, b);
    if (frame_pos + 1 >= PAYLOAD_BYTES) begin
      pending_beats.push_back('{value: frame_crc[7:0], last: 1'b0});
      pending_beats.push_back('{value: frame_crc[15:8], last: 1'b1});
      frame_crc = CRC_INIT;
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
  endtask

  // Offer one payload byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_byte <= b;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    build_frame_beats(b);
    bytes_sent++;
  endtask

  // Stop sending and wait for every predicted beat to come out
  task automatic wait_frame_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic write_crc_span(input logic [SPAN_W-1:0] v);
    crc_span  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    span_setting   = v;
    cfg_valid     <= 1'b0;
    span_writes++;
    spans_seen[v]  = 1'b1;
  endtask

  // Reset span of eight: one frame of corner byte values
  task automatic test_default_span();
    logic [7:0] seq [8];
    seq = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Span of zero: trailer must stay at the initial value
  task automatic test_span_zero();
    logic [7:0] seq [8];
    seq = '{8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'hFF, 8'h00};
    wait_frame_drain();
    write_crc_span('0);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Span above the payload, then cut back halfway through the frame
  task automatic test_span_mid_frame();
    logic [7:0] head [4];
    logic [7:0] tail [4];
    head = '{8'h12, 8'h34, 8'h56, 8'h78};
    tail = '{8'h9A, 8'hBC, 8'hDE, 8'hF0};
    wait_frame_drain();
    write_crc_span('1);
    foreach (head[i]) send_byte(head[i]);
    wait_frame_drain();
    write_crc_span(SPAN_W'(6));
    foreach (tail[i]) send_byte(tail[i]);
  endtask

  // Bursts of random bytes under changing span, gaps and back-pressure
  task automatic test_random_traffic();
    int sent;
    int mode;
    int burst;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      mode      = $urandom_range(0, 5);
      quiet     = (mode == 0);
      stall_pct = (mode == 1) ? 70 : 25;
      if (mode == 2 || $urandom_range(0, 2) == 0) begin
        wait_frame_drain();
        if (mode != 2) write_crc_span(pick_span());
      end
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_BYTES; i++) begin
        send_byte(random_byte());
        sent++;
      end
    end
    quiet     = 1'b0;
    stall_pct = 25;
  endtask

  // Receiver: random stalls, none started in quiet stretches
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left  = stall_length() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each output beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat 0x%02h end %b", out_byte, frame_end));
      end else begin
        head_beat = pending_beats.pop_front();
        if (out_byte !== head_beat.value)
          report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h", out_byte, head_beat.value));
        if (frame_end !== head_beat.last)
          report_mismatch($sformatf("frame_end %b, want %b", frame_end, head_beat.last));
        if (head_beat.last) frames_done++;
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_beats.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    frame_crc    = CRC_INIT;
    frame_pos    = 0;
    span_setting = SPAN_RESET;
    stall_left   = 0;
    mismatches   = 0;
    bytes_sent   = 0;
    frames_done  = 0;
    span_writes  = 0;
    spans_seen   = '0;
    cycle_count  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_span();
    test_span_zero();
    test_span_mid_frame();
    test_random_traffic();

    wait_frame_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d payload bytes, %0d complete frames, %0d span writes",
             bytes_sent, frames_done, span_writes);
    $display("Span values exercised (bit per value 15..0): %b, mismatches: %0d",
             spans_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
